// ===== rtl/gpiom_pkg.sv =====
// Package: transaction kinds, register selectors and stage payload types for the GPIO port.
package gpiom_pkg;

  typedef enum logic [1:0] {
    KIND_READ   = 2'd0,
    KIND_WRITE  = 2'd1,
    KIND_SAMPLE = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  localparam logic [4:0] SEL_DATA      = 5'd0;
  localparam logic [4:0] SEL_DIR       = 5'd1;
  localparam logic [4:0] SEL_SENSE     = 5'd2;
  localparam logic [4:0] SEL_BOTHEDGE  = 5'd3;
  localparam logic [4:0] SEL_EVENT     = 5'd4;
  localparam logic [4:0] SEL_MASK      = 5'd5;
  localparam logic [4:0] SEL_RAW       = 5'd6;
  localparam logic [4:0] SEL_MASKED    = 5'd7;
  localparam logic [4:0] SEL_CLEAR     = 5'd8;
  localparam logic [4:0] SEL_ALTSEL    = 5'd9;
  localparam logic [4:0] SEL_PULLUP    = 5'd10;
  localparam logic [4:0] SEL_PULLDOWN  = 5'd11;
  localparam logic [4:0] SEL_DIGEN     = 5'd12;
  localparam logic [4:0] SEL_ANALOG    = 5'd13;
  localparam logic [4:0] SEL_LOCK      = 5'd14;
  localparam logic [4:0] SEL_COMMIT    = 5'd15;
  localparam logic [4:0] SEL_OPENDRAIN = 5'd16;

  localparam int unsigned NumPins = 8;

  typedef struct packed {
    kind_e               kind;
    logic [4:0]          reg_sel;
    logic [NumPins-1:0]  addr_mask;
    logic [31:0]         write_data;
    logic [NumPins-1:0]  pin_levels;
  } item_t;

  typedef struct packed {
    logic [NumPins-1:0] read_data;
    logic [NumPins-1:0] pin_drive;
    logic [NumPins-1:0] pin_output_enable;
    logic [NumPins-1:0] pull_up_enable;
    logic [NumPins-1:0] pull_down_enable;
    logic               irq;
  } result_t;

endpackage

// ===== rtl/gpiom_core.sv =====
// Register file and single-pass update logic of the GPIO port.
module gpiom_core import gpiom_pkg::*; #(
  parameter logic [31:0]        UNLOCK_KEY   = 32'd1280262987,
  parameter logic [NumPins-1:0] COMMIT_RESET = 8'd255
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  item_t   item_i,
  output result_t result_o
);

  logic [NumPins-1:0] latch_q, latch_d, dir_q, dir_d, sense_q, sense_d;
  logic [NumPins-1:0] both_q, both_d, event_q, event_d, mask_q, mask_d;
  logic [NumPins-1:0] raw_q, raw_d, alt_q, alt_d, pu_q, pu_d, pd_q, pd_d;
  logic [NumPins-1:0] digen_q, digen_d, analog_q, analog_d, od_q, od_d;
  logic [NumPins-1:0] commit_q, commit_d, last_q, last_d;
  logic               lock_q, lock_d;

  logic [NumPins-1:0] wd, eff, rise, fall, edge_hit, lvl, rd;

  // Qualify written bits by commit, detect pin events
  assign wd       = item_i.write_data[NumPins-1:0];
  assign eff      = wd & commit_q;
  assign rise     = ~last_q & item_i.pin_levels;
  assign fall     = last_q & ~item_i.pin_levels;
  assign edge_hit = (both_q & (rise | fall)) |
                    (~both_q & ((event_q & rise) | (~event_q & fall)));
  assign lvl      = ~(item_i.pin_levels ^ event_q);

  // Compute next state and read value for the current transaction
  always_comb begin
    latch_d  = latch_q;
    dir_d    = dir_q;
    sense_d  = sense_q;
    both_d   = both_q;
    event_d  = event_q;
    mask_d   = mask_q;
    raw_d    = raw_q;
    alt_d    = alt_q;
    pu_d     = pu_q;
    pd_d     = pd_q;
    digen_d  = digen_q;
    analog_d = analog_q;
    od_d     = od_q;
    commit_d = commit_q;
    last_d   = last_q;
    lock_d   = lock_q;
    rd       = '0;
    unique case (item_i.kind)
      KIND_READ: begin
        unique case (item_i.reg_sel)
          SEL_DATA:      rd = ((dir_q & latch_q) | (~dir_q & last_q)) & item_i.addr_mask;
          SEL_DIR:       rd = dir_q;
          SEL_SENSE:     rd = sense_q;
          SEL_BOTHEDGE:  rd = both_q;
          SEL_EVENT:     rd = event_q;
          SEL_MASK:      rd = mask_q;
          SEL_RAW:       rd = raw_q;
          SEL_MASKED:    rd = raw_q & mask_q;
          SEL_ALTSEL:    rd = alt_q;
          SEL_PULLUP:    rd = pu_q;
          SEL_PULLDOWN:  rd = pd_q;
          SEL_DIGEN:     rd = digen_q;
          SEL_ANALOG:    rd = analog_q;
          SEL_LOCK:      rd = {{(NumPins-1){1'b0}}, lock_q};
          SEL_COMMIT:    rd = commit_q;
          SEL_OPENDRAIN: rd = od_q;
          default:       rd = '0;
        endcase
      end
      KIND_WRITE: begin
        unique case (item_i.reg_sel)
          SEL_DATA:      latch_d = (latch_q & ~item_i.addr_mask) | (wd & item_i.addr_mask);
          SEL_DIR:       dir_d = wd;
          SEL_SENSE:     sense_d = wd;
          SEL_BOTHEDGE:  both_d = wd;
          SEL_EVENT:     event_d = wd;
          SEL_MASK:      mask_d = wd;
          SEL_CLEAR:     raw_d = raw_q & ~(wd & ~sense_q);
          SEL_ALTSEL:    alt_d = (alt_q & ~commit_q) | eff;
          SEL_PULLUP: begin
            pu_d = (pu_q & ~commit_q) | eff;
            pd_d = pd_q & ~eff;
          end
          SEL_PULLDOWN: begin
            pd_d = (pd_q & ~commit_q) | eff;
            pu_d = pu_q & ~eff;
          end
          SEL_DIGEN:     digen_d = (digen_q & ~commit_q) | eff;
          SEL_ANALOG:    analog_d = wd;
          SEL_LOCK:      lock_d = (item_i.write_data != UNLOCK_KEY);
          SEL_COMMIT:    if (!lock_q) commit_d = wd;
          SEL_OPENDRAIN: od_d = wd;
          default:       ;
        endcase
      end
      KIND_SAMPLE: begin
        raw_d  = (sense_q & lvl) | (~sense_q & (raw_q | edge_hit));
        last_d = item_i.pin_levels;
      end
      default: ;
    endcase
  end

  // Hold register state; advance on each processed transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latch_q  <= '0;
      dir_q    <= '0;
      sense_q  <= '0;
      both_q   <= '0;
      event_q  <= '0;
      mask_q   <= '0;
      raw_q    <= '0;
      alt_q    <= '0;
      pu_q     <= '0;
      pd_q     <= '0;
      digen_q  <= '0;
      analog_q <= '0;
      od_q     <= '0;
      commit_q <= COMMIT_RESET;
      last_q   <= '0;
      lock_q   <= 1'b1;
    end else if (step_i) begin
      latch_q  <= latch_d;
      dir_q    <= dir_d;
      sense_q  <= sense_d;
      both_q   <= both_d;
      event_q  <= event_d;
      mask_q   <= mask_d;
      raw_q    <= raw_d;
      alt_q    <= alt_d;
      pu_q     <= pu_d;
      pd_q     <= pd_d;
      digen_q  <= digen_d;
      analog_q <= analog_d;
      od_q     <= od_d;
      commit_q <= commit_d;
      last_q   <= last_d;
      lock_q   <= lock_d;
    end
  end

  // Report the state as it stands after the transaction
  assign result_o.read_data         = rd;
  assign result_o.pin_drive         = latch_d;
  assign result_o.pin_output_enable = dir_d & digen_d & ~alt_d;
  assign result_o.pull_up_enable    = pu_d;
  assign result_o.pull_down_enable  = pd_d;
  assign result_o.irq               = |(raw_d & mask_d);

endmodule

// ===== rtl/gpio_port_masked_access_irq_unit.sv =====
// Top level of the GPIO port: input register, update core and result register.
//
// Usage: one input channel (in_valid_i / in_ready_o) carries bus reads, bus
// writes and pin sample ticks; one output channel (out_valid_o / out_ready_i)
// returns exactly one result transaction per input transaction, in order.
// Each result shows the read value and the pin controls after its transaction.
// Path: an accepted transaction is registered in the input stage, then
// processed through the update core when the result register is free or
// being emptied, and loaded into the result register, which then holds
// out_valid_o high until the result is taken.
// Throughput: one transaction per cycle while out_ready_i stays high, set by
// the register update between the input stage and the result register.
// Reset: all port registers clear, commit bits load COMMIT_RESET and the port
// comes up locked; both stages come up empty.
// Stall: while out_ready_i is low the result holds; the input stage still
// takes one more transaction, then in_ready_o drops until the result is taken.
module gpio_port_masked_access_irq_unit import gpiom_pkg::*; #(
  parameter logic [31:0] UNLOCK_KEY   = 32'd1280262987,
  parameter logic [7:0]  COMMIT_RESET = 8'd255
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [4:0]  reg_sel_i,
  input  logic [7:0]  addr_mask_i,
  input  logic [31:0] write_data_i,
  input  logic [7:0]  pin_levels_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  read_data_o,
  output logic [7:0]  pin_drive_o,
  output logic [7:0]  pin_output_enable_o,
  output logic [7:0]  pull_up_enable_o,
  output logic [7:0]  pull_down_enable_o,
  output logic        irq_o
);

  item_t   in_q;
  logic    in_vld_q;
  result_t res, out_q;
  logic    out_vld_q;
  logic    advance;

  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  // Input stage: capture accepted transactions, drop them once processed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q.kind       <= kind_e'(kind_i);
      in_q.reg_sel    <= reg_sel_i;
      in_q.addr_mask  <= addr_mask_i;
      in_q.write_data <= write_data_i;
      in_q.pin_levels <= pin_levels_i;
    end
  end

  gpiom_core #(
    .UNLOCK_KEY  (UNLOCK_KEY),
    .COMMIT_RESET(COMMIT_RESET)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .item_i  (in_q),
    .result_o(res)
  );

  // Result stage: load on advance, hold while the receiver stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign out_valid_o         = out_vld_q;
  assign read_data_o         = out_q.read_data;
  assign pin_drive_o         = out_q.pin_drive;
  assign pin_output_enable_o = out_q.pin_output_enable;
  assign pull_up_enable_o    = out_q.pull_up_enable;
  assign pull_down_enable_o  = out_q.pull_down_enable;
  assign irq_o               = out_q.irq;

endmodule
